/* src/spmd_pkg.sv */
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types and constants for the sequenced packet message deframer.
// ----------------------------------------------------------------------------
package spmd_pkg;

    localparam int SessionTopBytes = 2;
    localparam int SessionBytes    = 10;
    localparam int SequenceEnd     = 18;
    localparam int HeaderBytes     = 20;

    localparam logic [15:0] END_OF_SESSION_COUNT = 16'hFFFF;
    localparam logic [15:0] POSITION_MAX         = 16'hFFFF;

    localparam logic RECORD_MESSAGE     = 1'b0;
    localparam logic RECORD_END_SESSION = 1'b1;

    // output word: 200 bits of record fields, kind on tuser
    localparam int OUT_DATA_W = 200;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_IGNORE
    } phase_t;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] session_top;
        logic [63:0] session_rest;
        logic [63:0] message_sequence;
        logic [15:0] message_count;
        logic [7:0]  message_type;
        logic [15:0] message_length;
        logic [15:0] payload_offset;
    } record_t;

endpackage

/* src/sequenced_packet_message_deframer_core.sv */
// ----------------------------------------------------------------------------
// sequenced_packet_message_deframer_core
// Splits a sequenced packet stream into per-message records.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one packet byte per word; tlast marks the packet's last
//   byte. The first 20 bytes are the header (10-byte session, 64-bit
//   sequence, 16-bit count, big-endian), followed by length-prefixed
//   messages.
//   m_axis carries one record per complete nonzero-length message, or one
//   end-of-session record (tuser = 1) when the count is 0xFFFF.
//   Path: the word that completes a record passes the input register, then
//   the result register, which drives the record onto m_axis.
//   Throughput: one byte per cycle while m_axis is not stalled; the parser
//   sits between the two registers and updates all of its state per step.
//   Reset: both registers empty, parser back at the start of a header.
//   Stall: while m_axis_tready is low a held record blocks the parser stage;
//   s_axis_tready drops only once the input register is also occupied.
// ----------------------------------------------------------------------------
module sequenced_packet_message_deframer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [7:0]                           s_axis_tdata,  // [7:0] data_byte
    input  logic                                 s_axis_tlast,  // packet_end
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [15:0] session_top, [79:16] session_rest, [143:80] message_sequence,
    // [159:144] message_count, [167:160] message_type,
    // [183:168] message_length, [199:184] payload_offset
    output logic [spmd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tuser   // [0] record_kind
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    spmd_pkg::record_t out_rec_reg;

    logic              out_ready;
    logic              step;
    logic              rec_valid;
    spmd_pkg::record_t rec;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    spmd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (in_byte_reg),
        .packet_end (in_last_reg),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= step && rec_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && step && rec_valid)
            out_rec_reg <= rec;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rec_reg.record_kind;
    assign m_axis_tdata  = {out_rec_reg.payload_offset,
                            out_rec_reg.message_length,
                            out_rec_reg.message_type,
                            out_rec_reg.message_count,
                            out_rec_reg.message_sequence,
                            out_rec_reg.session_rest,
                            out_rec_reg.session_top};

endmodule

/* src/spmd_parser.sv */
// ----------------------------------------------------------------------------
// spmd_parser
// Per-byte header and message parser; updates its state on each step and
// flags the record that the byte completes.
// ----------------------------------------------------------------------------
module spmd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                packet_end,
    output logic                rec_valid,
    output spmd_pkg::record_t   rec
);

    spmd_pkg::phase_t phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] sess_hi_reg, sess_hi_next;
    logic [63:0] sess_lo_reg, sess_lo_next;
    logic [63:0] base_reg, base_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] start_reg, start_next;

    logic [15:0] idx_inc;
    logic [15:0] rem_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= spmd_pkg::PH_HEADER;
            pos_reg     <= '0;
            sess_hi_reg <= '0;
            sess_lo_reg <= '0;
            base_reg    <= '0;
            count_reg   <= '0;
            idx_reg     <= '0;
            len_reg     <= '0;
            rem_reg     <= '0;
            type_reg    <= '0;
            start_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            sess_hi_reg <= sess_hi_next;
            sess_lo_reg <= sess_lo_next;
            base_reg    <= base_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            rem_reg     <= rem_next;
            type_reg    <= type_next;
            start_reg   <= start_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        sess_hi_next = sess_hi_reg;
        sess_lo_next = sess_lo_reg;
        base_next    = base_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        rem_next     = rem_reg;
        type_next    = type_reg;
        start_next   = start_reg;
        idx_inc      = idx_reg + 16'd1;
        rem_dec      = (rem_reg != 16'd0) ? (rem_reg - 16'd1) : 16'd0;

        rec_valid            = 1'b0;
        rec.record_kind      = spmd_pkg::RECORD_MESSAGE;
        rec.session_top      = sess_hi_reg;
        rec.session_rest     = sess_lo_reg;
        rec.message_sequence = base_reg + {48'd0, idx_reg};
        rec.message_count    = count_reg;
        rec.message_type     = type_reg;
        rec.message_length   = len_reg;
        rec.payload_offset   = start_reg;

        unique case (phase_reg)
            spmd_pkg::PH_HEADER:
            begin
                if (pos_reg < 16'(spmd_pkg::SessionTopBytes))
                    sess_hi_next = {sess_hi_reg[7:0], data_byte};
                else if (pos_reg < 16'(spmd_pkg::SessionBytes))
                    sess_lo_next = {sess_lo_reg[55:0], data_byte};
                else if (pos_reg < 16'(spmd_pkg::SequenceEnd))
                    base_next = {base_reg[55:0], data_byte};
                else
                    count_next = {count_reg[7:0], data_byte};

                if (pos_reg == 16'(spmd_pkg::HeaderBytes - 1))
                begin
                    idx_next = '0;
                    if (count_next == spmd_pkg::END_OF_SESSION_COUNT)
                    begin
                        rec_valid            = 1'b1;
                        rec.record_kind      = spmd_pkg::RECORD_END_SESSION;
                        rec.message_sequence = base_reg;
                        rec.message_count    = count_next;
                        rec.message_type     = '0;
                        rec.message_length   = '0;
                        rec.payload_offset   = '0;
                        phase_next           = spmd_pkg::PH_IGNORE;
                    end
                    else if (count_next == 16'd0)
                        phase_next = spmd_pkg::PH_IGNORE;
                    else
                        phase_next = spmd_pkg::PH_LEN_HI;
                end
            end
            spmd_pkg::PH_LEN_HI:
            begin
                len_next   = {data_byte, 8'h00};
                phase_next = spmd_pkg::PH_LEN_LO;
            end
            spmd_pkg::PH_LEN_LO:
            begin
                len_next = {len_reg[15:8], data_byte};
                if (len_next == 16'd0)
                begin
                    // empty message: burn an index, no record
                    idx_next   = idx_inc;
                    phase_next = (idx_inc >= count_reg) ? spmd_pkg::PH_IGNORE
                                                        : spmd_pkg::PH_LEN_HI;
                end
                else
                begin
                    start_next = (pos_reg == spmd_pkg::POSITION_MAX) ? spmd_pkg::POSITION_MAX
                                                                      : pos_reg + 16'd1;
                    rem_next   = len_next;
                    phase_next = spmd_pkg::PH_PAYLOAD;
                end
            end
            spmd_pkg::PH_PAYLOAD:
            begin
                if (rem_reg == len_reg)
                    type_next = data_byte;
                rem_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    rec_valid        = 1'b1;
                    rec.message_type = type_next;
                    idx_next         = idx_inc;
                    phase_next       = (idx_inc >= count_reg) ? spmd_pkg::PH_IGNORE
                                                              : spmd_pkg::PH_LEN_HI;
                end
            end
            spmd_pkg::PH_IGNORE:
            begin
                phase_next = spmd_pkg::PH_IGNORE;
            end
            default:
            begin
                phase_next = spmd_pkg::PH_IGNORE;
            end
        endcase

        pos_next = (pos_reg == spmd_pkg::POSITION_MAX) ? pos_reg : pos_reg + 16'd1;

        if (packet_end)
        begin
            phase_next = spmd_pkg::PH_HEADER;
            pos_next   = '0;
        end
    end

endmodule

/* src/spmd_checker.sv */
// ----------------------------------------------------------------------------
// spmd_checker
// Port-level checks on the deframer's record stream.
// ----------------------------------------------------------------------------
module spmd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spmd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    // a stalled record holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("record changed while stalled");

    // end of session: count is all ones, type/length/offset zero
    a_eos_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spmd_pkg::RECORD_END_SESSION) |->
            m_axis_tdata[159:144] == spmd_pkg::END_OF_SESSION_COUNT
            && m_axis_tdata[199:160] == 40'd0)
        else $error("malformed end-of-session record");

    // empty messages never produce a record
    a_msg_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spmd_pkg::RECORD_MESSAGE) |->
            m_axis_tdata[183:168] != 16'd0)
        else $error("message record with zero length");

    // payload always starts after the header and a length prefix
    a_msg_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spmd_pkg::RECORD_MESSAGE) |->
            m_axis_tdata[199:184] >= 16'(spmd_pkg::HeaderBytes + 2))
        else $error("payload offset inside header");

    // a message record needs a count that is neither zero nor end of session
    a_msg_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == spmd_pkg::RECORD_MESSAGE) |->
            m_axis_tdata[159:144] != 16'd0
            && m_axis_tdata[159:144] != spmd_pkg::END_OF_SESSION_COUNT)
        else $error("message record with invalid count");

endmodule

bind sequenced_packet_message_deframer_core spmd_checker u_spmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/sequenced_packet_message_deframer_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sequenced_packet_message_deframer_core_tb
// Self-checking bench: packets go in as byte words, and every record that
// comes out is compared field by field against an in-bench deframer model
// or a hand-built expected record. Hand-built packets from a short table run
// first; mostly well-formed random packets follow in four idle/stall mixes.
// ----------------------------------------------------------------------------
module sequenced_packet_message_deframer_core_tb;

    localparam int WatchdogLimit = 4000;
    localparam int HoldCycles    = 80;
    localparam int PhaseBytes    = 30;
    localparam int PhaseRecords  = 3;
    localparam int PrintLimit    = 40;

    typedef enum int { CHK_PREDICT, CHK_NONE, CHK_RECORD } chk_mode_t;

    typedef struct {
        logic [79:0]       session;
        logic [63:0]       seq;
        logic [15:0]       count;
        int                nmsg;
        logic [15:0]       len0;
        logic [15:0]       len1;
        logic [15:0]       len2;
        logic [7:0]        mtype;
        int                trail;
        int                cut;       // bytes sent; 0 means the whole packet
        chk_mode_t         mode;
        spmd_pkg::record_t rec;
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [spmd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;

    sequenced_packet_message_deframer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // deframer model state
    spmd_pkg::phase_t prs_phase = spmd_pkg::PH_HEADER;
    logic [15:0] pos_cnt   = '0;
    logic [15:0] sess_hi   = '0;
    logic [63:0] sess_lo   = '0;
    logic [63:0] seq_base  = '0;
    logic [15:0] msg_count = '0;
    logic [15:0] msg_idx   = '0;
    logic [15:0] msg_len   = '0;
    logic [15:0] remain    = '0;
    logic [7:0]  cur_type  = '0;
    logic [15:0] pay_off   = '0;

    spmd_pkg::record_t pending_records[$];
    logic [7:0]        pkt[$];
    dir_row_t          directed[$];

    int  src_idle_pct    = 0;
    int  snk_stall_pct   = 0;
    bit  use_predictor   = 1'b1;
    bit  pressure_go     = 1'b0;
    bit  hold_on         = 1'b0;
    int  mismatch_count  = 0;
    int  bytes_sent      = 0;
    int  packets_sent    = 0;
    int  records_queued  = 0;
    int  records_checked = 0;
    int  quiet_cycles    = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PrintLimit)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic push_record(input spmd_pkg::record_t rec);
        pending_records.push_back(rec);
        records_queued++;
    endtask

    function automatic spmd_pkg::record_t mk_rec(input logic kind, input logic [15:0] top,
                                       input logic [63:0] rest, input logic [63:0] seq,
                                       input logic [15:0] count, input logic [7:0] mtype,
                                       input logic [15:0] len, input logic [15:0] off);
        spmd_pkg::record_t r;
        r = {kind, top, rest, seq, count, mtype, len, off};
        return r;
    endfunction

    function automatic spmd_pkg::record_t model_record(input logic kind,
                                             input logic [63:0] seq,
                                             input logic [7:0] mtype,
                                             input logic [15:0] len,
                                             input logic [15:0] off);
        return mk_rec(kind, sess_hi, sess_lo, seq, msg_count, mtype, len, off);
    endfunction

    task automatic advance_message();
        msg_idx   = msg_idx + 16'd1;
        prs_phase = (msg_idx >= msg_count) ? spmd_pkg::PH_IGNORE : spmd_pkg::PH_LEN_HI;
    endtask

    // one accepted byte through the model; at most one record out
    task automatic deframe_step(input logic [7:0] b, input logic last,
                                output logic got_rec, output spmd_pkg::record_t rec);
        logic [15:0] pos;
        pos     = pos_cnt;
        got_rec = 1'b0;
        rec     = '0;
        case (prs_phase)
            spmd_pkg::PH_HEADER:
            begin
                if (pos < spmd_pkg::SessionTopBytes)
                    sess_hi = {sess_hi[7:0], b};
                else if (pos < spmd_pkg::SessionBytes)
                    sess_lo = {sess_lo[55:0], b};
                else if (pos < spmd_pkg::SequenceEnd)
                    seq_base = {seq_base[55:0], b};
                else
                    msg_count = {msg_count[7:0], b};
                if (pos == spmd_pkg::HeaderBytes - 1)
                begin
                    msg_idx = '0;
                    if (msg_count == spmd_pkg::END_OF_SESSION_COUNT)
                    begin
                        rec       = model_record(spmd_pkg::RECORD_END_SESSION, seq_base,
                                                 8'h00, 16'h0000, 16'h0000);
                        got_rec   = 1'b1;
                        prs_phase = spmd_pkg::PH_IGNORE;
                    end
                    else if (msg_count == 16'h0000)
                        prs_phase = spmd_pkg::PH_IGNORE;
                    else
                        prs_phase = spmd_pkg::PH_LEN_HI;
                end
            end
            spmd_pkg::PH_LEN_HI:
            begin
                msg_len   = {b, 8'h00};
                prs_phase = spmd_pkg::PH_LEN_LO;
            end
            spmd_pkg::PH_LEN_LO:
            begin
                msg_len[7:0] = b;
                if (msg_len == 16'h0000)
                    advance_message();
                else
                begin
                    pay_off   = (pos == spmd_pkg::POSITION_MAX) ? spmd_pkg::POSITION_MAX
                                                                : pos + 16'd1;
                    remain    = msg_len;
                    prs_phase = spmd_pkg::PH_PAYLOAD;
                end
            end
            spmd_pkg::PH_PAYLOAD:
            begin
                if (remain == msg_len)
                    cur_type = b;
                if (remain != 16'h0000)
                    remain = remain - 16'd1;
                if (remain == 16'h0000)
                begin
                    rec     = model_record(spmd_pkg::RECORD_MESSAGE, seq_base + 64'(msg_idx),
                                           cur_type, msg_len, pay_off);
                    got_rec = 1'b1;
                    advance_message();
                end
            end
            default: ;
        endcase
        if (pos_cnt != spmd_pkg::POSITION_MAX)
            pos_cnt = pos_cnt + 16'd1;
        if (last)
        begin
            prs_phase = spmd_pkg::PH_HEADER;
            pos_cnt   = '0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        logic              got_rec;
        spmd_pkg::record_t rec;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        deframe_step(b, last, got_rec, rec);
        if (got_rec && use_predictor)
            push_record(rec);
    endtask

    function automatic void add_header(input logic [79:0] session, input logic [63:0] seq,
                                       input logic [15:0] count);
        for (int i = 0; i < 10; i++)
            pkt.push_back(session[79-8*i -: 8]);
        for (int i = 0; i < 8; i++)
            pkt.push_back(seq[63-8*i -: 8]);
        pkt.push_back(count[15:8]);
        pkt.push_back(count[7:0]);
    endfunction

    function automatic void add_message(input logic [15:0] len, input logic [7:0] first);
        pkt.push_back(len[15:8]);
        pkt.push_back(len[7:0]);
        for (int i = 0; i < int'(len); i++)
            pkt.push_back(i == 0 ? first : 8'($urandom));
    endfunction

    function automatic void add_noise(input int n);
        for (int i = 0; i < n; i++)
            pkt.push_back(8'($urandom));
    endfunction

    task automatic send_packet(input int cut);
        int n;
        n = (cut <= 0 || cut > pkt.size()) ? pkt.size() : cut;
        for (int i = 0; i < n; i++)
            send_byte(pkt[i], i == n - 1);
        pkt.delete();
        packets_sent++;
    endtask

    function automatic logic [79:0] rand_session();
        return {16'($urandom), $urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_sequence();
        if ($urandom_range(3) == 0)
            return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(4));
        return {$urandom, $urandom};
    endfunction

    function automatic logic [15:0] rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 16'h0000;
        if (r < 98)
            return 16'($urandom_range(1, 8));
        return 16'($urandom_range(20, 60));
    endfunction

    // mostly well-formed packets; the rest end-of-session, empty, cut or noise
    task automatic send_random_packet();
        int          r;
        int          nmsg;
        logic [15:0] count;
        r = $urandom_range(99);
        if (r < 70 || (r >= 83 && r < 92))
        begin
            nmsg  = $urandom_range(1, 6);
            count = 16'(nmsg);
            if ($urandom_range(9) == 0)
                count = 16'($urandom_range(1, 16'hFFFE));
            add_header(rand_session(), rand_sequence(), count);
            for (int i = 0; i < nmsg; i++)
                add_message(rand_length(), 8'($urandom));
            if ($urandom_range(3) == 0)
                add_noise($urandom_range(1, 4));
            send_packet(r < 70 ? 0 : $urandom_range(1, pkt.size()));
        end
        else if (r < 78)
        begin
            add_header(rand_session(), rand_sequence(), spmd_pkg::END_OF_SESSION_COUNT);
            add_noise($urandom_range(0, 6));
            send_packet(0);
        end
        else if (r < 83)
        begin
            add_header(rand_session(), rand_sequence(), 16'h0000);
            add_noise($urandom_range(0, 6));
            send_packet(0);
        end
        else
        begin
            add_noise($urandom_range(1, 30));
            send_packet(0);
        end
    endtask

    function automatic dir_row_t mk_row(input logic [79:0] session, input logic [63:0] seq,
                                        input logic [15:0] count, input int nmsg,
                                        input logic [15:0] len0, input logic [15:0] len1,
                                        input logic [15:0] len2, input logic [7:0] mtype,
                                        input int trail, input int cut,
                                        input chk_mode_t mode,
                                        input spmd_pkg::record_t rec);
        dir_row_t row;
        row.session = session;
        row.seq     = seq;
        row.count   = count;
        row.nmsg    = nmsg;
        row.len0    = len0;
        row.len1    = len1;
        row.len2    = len2;
        row.mtype   = mtype;
        row.trail   = trail;
        row.cut     = cut;
        row.mode    = mode;
        row.rec     = rec;
        return row;
    endfunction

    // receiver: ready pattern plus record check
    initial
    begin
        spmd_pkg::record_t got;
        spmd_pkg::record_t want;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.record_kind      = m_axis_tuser;
                got.session_top      = m_axis_tdata[15:0];
                got.session_rest     = m_axis_tdata[79:16];
                got.message_sequence = m_axis_tdata[143:80];
                got.message_count    = m_axis_tdata[159:144];
                got.message_type     = m_axis_tdata[167:160];
                got.message_length   = m_axis_tdata[183:168];
                got.payload_offset   = m_axis_tdata[199:184];
                records_checked++;
                if (pending_records.size() == 0)
                    report_mismatch("record with none pending", got.message_sequence, '0);
                else
                begin
                    want = pending_records.pop_front();
                    if (got.record_kind !== want.record_kind)
                        report_mismatch("record_kind", got.record_kind, want.record_kind);
                    if (got.session_top !== want.session_top)
                        report_mismatch("session_top", got.session_top, want.session_top);
                    if (got.session_rest !== want.session_rest)
                        report_mismatch("session_rest", got.session_rest, want.session_rest);
                    if (got.message_sequence !== want.message_sequence)
                        report_mismatch("message_sequence", got.message_sequence,
                                        want.message_sequence);
                    if (got.message_count !== want.message_count)
                        report_mismatch("message_count", got.message_count,
                                        want.message_count);
                    if (got.message_type !== want.message_type)
                        report_mismatch("message_type", got.message_type, want.message_type);
                    if (got.message_length !== want.message_length)
                        report_mismatch("message_length", got.message_length,
                                        want.message_length);
                    if (got.payload_offset !== want.payload_offset)
                        report_mismatch("payload_offset", got.payload_offset,
                                        want.payload_offset);
                end
            end
            m_axis_tready <= !hold_on && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // long receiver hold-off so both pipeline registers fill and input stalls
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_on <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("timeout: no word moved for %0d cycles", WatchdogLimit);
                $display("sequenced_packet_message_deframer_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int src_pcts[4];
        int snk_pcts[4];
        int b0;
        int r0;
        dir_row_t row;

        src_pcts = '{0, 62, 0, 24};
        snk_pcts = '{0, 0, 62, 24};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;

        // hand-built packets; typed records only where obvious
        directed.push_back(mk_row('0, '0, 16'd1, 1, 16'd1, 0, 0, 8'hFF, 0, 0, CHK_RECORD,
            mk_rec(spmd_pkg::RECORD_MESSAGE, 16'h0000, 64'h0, 64'h0, 16'd1, 8'hFF, 16'd1,
                   16'd22)));
        // sequence wraps on the third message, zero-length one in the middle
        directed.push_back(mk_row('1, '1, 16'd3, 3, 16'd2, 16'd0, 16'd1, 8'h00, 0, 0,
            CHK_PREDICT, '0));
        directed.push_back(mk_row(80'h0102_0304_0506_0708_090A, 64'h0123_4567_89AB_CDEF,
            spmd_pkg::END_OF_SESSION_COUNT, 0, 0, 0, 0, 0, 6, 0, CHK_RECORD,
            mk_rec(spmd_pkg::RECORD_END_SESSION, 16'h0102, 64'h0304_0506_0708_090A,
                   64'h0123_4567_89AB_CDEF, 16'hFFFF, 8'h00, 16'h0000, 16'h0000)));
        // end of session with the packet ending on the last header byte
        directed.push_back(mk_row('1, '0, spmd_pkg::END_OF_SESSION_COUNT, 0, 0, 0, 0, 0, 0, 0,
            CHK_RECORD, mk_rec(spmd_pkg::RECORD_END_SESSION, 16'hFFFF, '1, '0, 16'hFFFF,
                               8'h00, 16'h0000, 16'h0000)));
        directed.push_back(mk_row('1, '1, 16'd0, 0, 0, 0, 0, 0, 5, 0, CHK_NONE, '0));
        directed.push_back(mk_row('1, '1, 16'd1, 1, 16'd3, 0, 0, 8'h11, 0, 13, CHK_NONE, '0));
        directed.push_back(mk_row('0, '1, 16'd1, 1, 16'd3, 0, 0, 8'h22, 0, 21, CHK_NONE, '0));
        directed.push_back(mk_row('0, '0, 16'd2, 0, 0, 0, 0, 0, 0, 20, CHK_NONE, '0));
        directed.push_back(mk_row('0, '0, 16'd1, 0, 0, 0, 0, 0, 0, 1, CHK_NONE, '0));
        // second message cut off inside its payload
        directed.push_back(mk_row('1, 64'h10, 16'd2, 2, 16'd2, 16'd4, 0, 8'h5A, 0, 29,
            CHK_PREDICT, '0));
        // trailing bytes past the counted message
        directed.push_back(mk_row(80'h1234, 64'h77, 16'd1, 1, 16'd3, 0, 0, 8'h80, 4, 0,
            CHK_PREDICT, '0));
        directed.push_back(mk_row('1, 64'h8000_0000_0000_0000, 16'hFFFE, 1, 16'h0010, 0, 0,
            8'hAA, 0, 0, CHK_PREDICT, '0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            row = directed[i];
            add_header(row.session, row.seq, row.count);
            if (row.nmsg > 0) add_message(row.len0, row.mtype);
            if (row.nmsg > 1) add_message(row.len1, row.mtype);
            if (row.nmsg > 2) add_message(row.len2, row.mtype);
            add_noise(row.trail);
            use_predictor = (row.mode == CHK_PREDICT);
            if (row.mode == CHK_RECORD)
                push_record(row.rec);
            send_packet(row.cut);
            use_predictor = 1'b1;
        end

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct  = src_pcts[p];
            snk_stall_pct = snk_pcts[p];
            if (p == 0)
            begin
                // receiver holds off while a burst of short messages streams in
                pressure_go = 1'b1;
                add_header(rand_session(), rand_sequence(), 16'd8);
                for (int k = 0; k < 8; k++)
                    add_message(16'd1, 8'($urandom));
                send_packet(0);
            end
            b0 = bytes_sent;
            r0 = records_queued;
            while (bytes_sent - b0 < PhaseBytes || records_queued - r0 < PhaseRecords)
                send_random_packet();
        end
        s_axis_tvalid <= 1'b0;

        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d packets, %0d bytes, %0d records checked",
                 packets_sent, bytes_sent, records_checked);
        $display("incl. short/cut/empty/end-of-session packets, sequence wrap, long stall");
        if (mismatch_count == 0)
            $display("sequenced_packet_message_deframer_core regression: pass");
        else
            $display("sequenced_packet_message_deframer_core regression: fail");
        $finish;
    end

endmodule
